// ===== hdl/polyline_length_min_max_segment_defines.svh =====
// ----------------------------------------------------------------------------
// polyline_length_min_max_segment_defines.svh
// assertion macros shared by the route length block
// ----------------------------------------------------------------------------
`ifndef POLYLINE_LENGTH_MIN_MAX_SEGMENT_DEFINES_SVH
`define POLYLINE_LENGTH_MIN_MAX_SEGMENT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PLMMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plmms assertion failed");

// next-cycle implication, disabled while reset is low
`define PLMMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plmms assertion failed");

`endif

// ===== hdl/plmms_pkg.sv =====
// ----------------------------------------------------------------------------
// plmms_pkg
// shared types and constants of the route length block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plmms_pkg;

  // default coordinate width and fixed total width
  localparam int COORD_WIDTH_DEF = 16;
  localparam int TOTAL_WIDTH     = 32;

  // controller states, one-hot
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQX  = 7'b0000010,
    S_SQY  = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_ROOT = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;     // latch the incoming point
    logic sq_x;       // square |dx|
    logic sq_y;       // square |dy|
    logic root_init;  // load radicand, clear root unit
    logic root_step;  // one digit of the square root
    logic commit;     // fold segment into the route stats
    logic emit;       // load the summary beat and clear the route
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic have_prior;
    logic fin;
    logic root_done;
  } status_t;

endpackage

// ===== hdl/plmms_ctrl.sv =====
// ----------------------------------------------------------------------------
// plmms_ctrl
// sequencer for one point: squares, root, stats update, summary beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polyline_length_min_max_segment_defines.svh"

module plmms_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  plmms_pkg::status_t status,
  output plmms_pkg::cmd_t    cmd
);
  import plmms_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = status.have_prior ? S_SQX : S_UPD;
        end
      end
      S_SQX: begin
        cmd.sq_x  = 1'b1;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.root_init = 1'b1;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_done) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.commit = 1'b1;
        state_nxt  = status.fin ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output beat holds until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // checks
  `PLMMS_ASSERT_NOW(a_emit_free, clk, rst_n, cmd.emit, (!out_valid_r || !out_stall))
  `PLMMS_ASSERT_NEXT(a_accept_path, clk, rst_n, (in_valid && !in_stall),
                     (state_r == S_SQX || state_r == S_UPD))
  `PLMMS_ASSERT_NEXT(a_root_stays, clk, rst_n, (state_r == S_ROOT && !status.root_done),
                     (state_r == S_ROOT))
  `PLMMS_ASSERT_NOW(a_emit_final, clk, rst_n, (state_r == S_EMIT), status.fin)

endmodule

// ===== hdl/plmms_dp.sv =====
// ----------------------------------------------------------------------------
// plmms_dp
// datapath: point registers, shared squarer, digit-serial root, route stats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plmms_dp #(
  parameter int COORD_WIDTH = plmms_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  plmms_pkg::cmd_t                      cmd,
  output plmms_pkg::status_t                   status,
  input  logic signed [COORD_WIDTH-1:0]        in_point_x,
  input  logic signed [COORD_WIDTH-1:0]        in_point_y,
  input  logic                                 in_is_final,
  output logic [plmms_pkg::TOTAL_WIDTH-1:0]    out_total_length,
  output logic [COORD_WIDTH:0]                 out_longest_length,
  output logic signed [COORD_WIDTH-1:0]        out_longest_start_x,
  output logic signed [COORD_WIDTH-1:0]        out_longest_start_y,
  output logic signed [COORD_WIDTH-1:0]        out_longest_end_x,
  output logic signed [COORD_WIDTH-1:0]        out_longest_end_y,
  output logic [COORD_WIDTH:0]                 out_shortest_length,
  output logic signed [COORD_WIDTH-1:0]        out_shortest_start_x,
  output logic signed [COORD_WIDTH-1:0]        out_shortest_start_y,
  output logic signed [COORD_WIDTH-1:0]        out_shortest_end_x,
  output logic signed [COORD_WIDTH-1:0]        out_shortest_end_y,
  output logic                                 out_too_few_points
);
  import plmms_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int LW    = W + 1;
  localparam int SQW   = 2 * W + 2;
  localparam int NSTEP = W + 2;
  localparam int RADW  = 2 * NSTEP;
  localparam int ROOTW = NSTEP;
  localparam int REMW  = W + 4;
  localparam int CNTW  = $clog2(NSTEP);

  // point and route registers
  logic signed [W-1:0] cur_x_r, cur_y_r, prior_x_r, prior_y_r;
  logic                fin_r, have_prior_r, have_segment_r;
  logic [TOTAL_WIDTH-1:0] total_r;
  logic [LW-1:0]       max_len_r, min_len_r;
  logic signed [W-1:0] max_sx_r, max_sy_r, max_ex_r, max_ey_r;
  logic signed [W-1:0] min_sx_r, min_sy_r, min_ex_r, min_ey_r;

  // squarer and root registers
  logic [SQW-1:0]  sqx_r, sqy_r;
  logic [RADW-1:0] rad_r;
  logic [REMW-1:0] rem_r;
  logic [ROOTW-1:0] root_r;
  logic [CNTW-1:0] cnt_r;

  // output beat registers
  logic [TOTAL_WIDTH-1:0] o_total_r;
  logic [LW-1:0]       o_max_len_r, o_min_len_r;
  logic signed [W-1:0] o_max_sx_r, o_max_sy_r, o_max_ex_r, o_max_ey_r;
  logic signed [W-1:0] o_min_sx_r, o_min_sy_r, o_min_ex_r, o_min_ey_r;
  logic                o_few_r;

  // coordinate differences and magnitudes
  logic signed [W:0] dx, dy;
  logic [W:0]        mag_x, mag_y, mul_a;
  logic [SQW-1:0]    sq;

  assign dx    = {cur_x_r[W-1], cur_x_r} - {prior_x_r[W-1], prior_x_r};
  assign dy    = {cur_y_r[W-1], cur_y_r} - {prior_y_r[W-1], prior_y_r};
  assign mag_x = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
  assign mag_y = dy[W] ? (W+1)'(-dy) : (W+1)'(dy);

  // one shared squarer
  assign mul_a = cmd.sq_y ? mag_y : mag_x;
  assign sq    = SQW'(mul_a) * SQW'(mul_a);

  // root digit step
  logic [REMW+1:0] rem_sh, trial;
  logic            fits;

  assign rem_sh = {rem_r, rad_r[RADW-1 -: 2]};
  assign trial  = (REMW+2)'({root_r, 2'b01});
  assign fits   = (rem_sh >= trial);

  // segment length and running sum
  logic [LW-1:0]          len;
  logic [TOTAL_WIDTH:0]   sum;
  logic [TOTAL_WIDTH-1:0] sum_sat;

  assign len     = root_r[LW-1:0];
  assign sum     = {1'b0, total_r} + (TOTAL_WIDTH+1)'(len);
  assign sum_sat = sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : sum[TOTAL_WIDTH-1:0];

  // route control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prior_r   <= 1'b0;
      have_segment_r <= 1'b0;
    end else if (cmd.emit) begin
      have_prior_r   <= 1'b0;
      have_segment_r <= 1'b0;
    end else if (cmd.commit) begin
      have_prior_r <= 1'b1;
      if (have_prior_r) have_segment_r <= 1'b1;
    end
  end

  // incoming point
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_x_r <= in_point_x;
      cur_y_r <= in_point_y;
      fin_r   <= in_is_final;
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (cmd.sq_x) sqx_r <= sq;
    if (cmd.sq_y) sqy_r <= sq;
  end

  // digit-by-digit square root, two radicand bits per step
  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad_r  <= RADW'(sqx_r) + RADW'(sqy_r);
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.root_step) begin
      rad_r <= rad_r << 2;
      cnt_r <= cnt_r + 1'b1;
      if (fits) begin
        rem_r  <= REMW'(rem_sh - trial);
        root_r <= {root_r[ROOTW-2:0], 1'b1};
      end else begin
        rem_r  <= REMW'(rem_sh);
        root_r <= {root_r[ROOTW-2:0], 1'b0};
      end
    end
  end

  // fold segment into stats; earliest segment wins ties
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      prior_x_r <= cur_x_r;
      prior_y_r <= cur_y_r;
      if (have_prior_r) begin
        total_r <= have_segment_r ? sum_sat : TOTAL_WIDTH'(len);
        if (!have_segment_r || len > max_len_r) begin
          max_len_r <= len;
          max_sx_r  <= prior_x_r;
          max_sy_r  <= prior_y_r;
          max_ex_r  <= cur_x_r;
          max_ey_r  <= cur_y_r;
        end
        if (!have_segment_r || len < min_len_r) begin
          min_len_r <= len;
          min_sx_r  <= prior_x_r;
          min_sy_r  <= prior_y_r;
          min_ex_r  <= cur_x_r;
          min_ey_r  <= cur_y_r;
        end
      end
    end
  end

  // summary beat: zero fields and too_few set when the route had no segment
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_few_r <= !have_segment_r;
      if (have_segment_r) begin
        o_total_r   <= total_r;
        o_max_len_r <= max_len_r;
        o_max_sx_r  <= max_sx_r;
        o_max_sy_r  <= max_sy_r;
        o_max_ex_r  <= max_ex_r;
        o_max_ey_r  <= max_ey_r;
        o_min_len_r <= min_len_r;
        o_min_sx_r  <= min_sx_r;
        o_min_sy_r  <= min_sy_r;
        o_min_ex_r  <= min_ex_r;
        o_min_ey_r  <= min_ey_r;
      end else begin
        o_total_r   <= '0;
        o_max_len_r <= '0;
        o_max_sx_r  <= '0;
        o_max_sy_r  <= '0;
        o_max_ex_r  <= '0;
        o_max_ey_r  <= '0;
        o_min_len_r <= '0;
        o_min_sx_r  <= '0;
        o_min_sy_r  <= '0;
        o_min_ex_r  <= '0;
        o_min_ey_r  <= '0;
      end
    end
  end

  // status
  assign status.have_prior = have_prior_r;
  assign status.fin        = fin_r;
  assign status.root_done  = (cnt_r == CNTW'(NSTEP - 1));

  // result ports
  assign out_total_length     = o_total_r;
  assign out_longest_length   = o_max_len_r;
  assign out_longest_start_x  = o_max_sx_r;
  assign out_longest_start_y  = o_max_sy_r;
  assign out_longest_end_x    = o_max_ex_r;
  assign out_longest_end_y    = o_max_ey_r;
  assign out_shortest_length  = o_min_len_r;
  assign out_shortest_start_x = o_min_sx_r;
  assign out_shortest_start_y = o_min_sy_r;
  assign out_shortest_end_x   = o_min_ex_r;
  assign out_shortest_end_y   = o_min_ey_r;
  assign out_too_few_points   = o_few_r;

endmodule

// ===== hdl/polyline_length_min_max_segment.sv =====
// ----------------------------------------------------------------------------
// polyline_length_min_max_segment
// route length with longest and shortest segment and their endpoints
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid / in_stall) carries one route point per beat,
//   signed fixed-point x and y plus in_is_final marking the last point.
//   output channel (out_valid / out_stall) carries one summary beat per
//   route: saturating total length, longest and shortest segment with both
//   endpoints, and too_few_points for a route of a single point.
//   each point after the first takes these steps: one to take the point,
//   two on the shared squarer, one to add, COORD_WIDTH+2 steps of the
//   digit-serial square root and one to update the stats. the first point
//   of a route is taken and then updates the stats. a final point adds a
//   step that loads the summary, which then shows on out_valid the next cycle.
//   in_stall is high whenever a point is in work.
//   the summary sits in an output register; the next route is taken while it
//   waits, and only the following summary waits for the receiver to lift
//   out_stall.
//   reset (rst_n low, synchronous) drops out_valid and starts a new route.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polyline_length_min_max_segment #(
  parameter int COORD_WIDTH = plmms_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     in_point_x,
  input  logic signed [COORD_WIDTH-1:0]     in_point_y,
  input  logic                              in_is_final,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [plmms_pkg::TOTAL_WIDTH-1:0] out_total_length,
  output logic [COORD_WIDTH:0]              out_longest_length,
  output logic signed [COORD_WIDTH-1:0]     out_longest_start_x,
  output logic signed [COORD_WIDTH-1:0]     out_longest_start_y,
  output logic signed [COORD_WIDTH-1:0]     out_longest_end_x,
  output logic signed [COORD_WIDTH-1:0]     out_longest_end_y,
  output logic [COORD_WIDTH:0]              out_shortest_length,
  output logic signed [COORD_WIDTH-1:0]     out_shortest_start_x,
  output logic signed [COORD_WIDTH-1:0]     out_shortest_start_y,
  output logic signed [COORD_WIDTH-1:0]     out_shortest_end_x,
  output logic signed [COORD_WIDTH-1:0]     out_shortest_end_y,
  output logic                              out_too_few_points
);
  import plmms_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  plmms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  plmms_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .in_is_final          (in_is_final),
    .out_total_length     (out_total_length),
    .out_longest_length   (out_longest_length),
    .out_longest_start_x  (out_longest_start_x),
    .out_longest_start_y  (out_longest_start_y),
    .out_longest_end_x    (out_longest_end_x),
    .out_longest_end_y    (out_longest_end_y),
    .out_shortest_length  (out_shortest_length),
    .out_shortest_start_x (out_shortest_start_x),
    .out_shortest_start_y (out_shortest_start_y),
    .out_shortest_end_x   (out_shortest_end_x),
    .out_shortest_end_y   (out_shortest_end_y),
    .out_too_few_points   (out_too_few_points)
  );

endmodule

// ===== dv/tb_polyline_length_min_max_segment.sv =====
// ----------------------------------------------------------------------------
// tb_polyline_length_min_max_segment
// self-checking bench for the route length block
// ----------------------------------------------------------------------------
// Route points go in on the valid/stall input channel. A scoreboard object
// keeps its own copy of the route state. From every accepted point it works
// out the summary that a final point must produce, and it compares each
// summary beat taken from the output channel, field by field, with the
// oldest one it is holding.
// The stimulus runs in phases:
//   - directed routes: single-point routes, extreme coordinates,
//     zero-length segments and equal-length ties
//   - random routes, with and without idle cycles on both sides
//   - a long receiver hold-off while short routes keep arriving
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_polyline_length_min_max_segment;

  localparam int CW          = plmms_pkg::COORD_WIDTH_DEF;
  localparam int TW          = plmms_pkg::TOTAL_WIDTH;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int HOLD_CYCLES = 400;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [CW:0]          len_t;

  typedef struct packed {
    logic [TW-1:0] total;
    len_t          longest;
    coord_t        long_sx;
    coord_t        long_sy;
    coord_t        long_ex;
    coord_t        long_ey;
    len_t          shortest;
    coord_t        short_sx;
    coord_t        short_sy;
    coord_t        short_ex;
    coord_t        short_ey;
    logic          too_few;
  } summary_t;

  // route statistics predictor and store of expected summaries
  class route_scoreboard;
    coord_t      prior_x, prior_y;
    bit          have_prior, have_segment;
    logic [TW:0] run_total;
    len_t        max_len, min_len;
    coord_t      max_ends[4];
    coord_t      min_ends[4];
    summary_t    summary_q[$];
    int unsigned mismatches;

    function new();
      prior_x    = '0;
      prior_y    = '0;
      mismatches = 0;
      clear_route();
    endfunction

    function void clear_route();
      have_prior   = 1'b0;
      have_segment = 1'b0;
      run_total    = '0;
      max_len      = '0;
      min_len      = '0;
      foreach (max_ends[k]) begin
        max_ends[k] = '0;
        min_ends[k] = '0;
      end
    endfunction

    // floor square root, one result bit per pass
    function longint unsigned floor_root(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = longint'(1) << 40;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function len_t segment_length(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
      longint dx, dy;
      dx = longint'(x1) - longint'(x0);
      dy = longint'(y1) - longint'(y0);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return len_t'(floor_root(longint'(dx * dx + dy * dy)));
    endfunction

    function int pending();
      return summary_q.size();
    endfunction

    // fold one accepted point into the route
    function void note_point(coord_t x, coord_t y, bit fin);
      len_t     seg;
      summary_t s;
      if (have_prior) begin
        seg       = segment_length(prior_x, prior_y, x, y);
        run_total = run_total + seg;
        if (run_total[TW]) run_total = {1'b0, {TW{1'b1}}};
        if (!have_segment || seg > max_len) begin
          max_len  = seg;
          max_ends = '{prior_x, prior_y, x, y};
        end
        if (!have_segment || seg < min_len) begin
          min_len  = seg;
          min_ends = '{prior_x, prior_y, x, y};
        end
        have_segment = 1'b1;
      end
      prior_x    = x;
      prior_y    = y;
      have_prior = 1'b1;
      if (!fin) return;

      s = '0;
      if (have_segment) begin
        s.total    = run_total[TW-1:0];
        s.longest  = max_len;
        s.long_sx  = max_ends[0];
        s.long_sy  = max_ends[1];
        s.long_ex  = max_ends[2];
        s.long_ey  = max_ends[3];
        s.shortest = min_len;
        s.short_sx = min_ends[0];
        s.short_sy = min_ends[1];
        s.short_ex = min_ends[2];
        s.short_ey = min_ends[3];
      end else begin
        s.too_few = 1'b1;
      end
      summary_q.push_back(s);
      clear_route();
    endfunction

    function void compare(string field, longint want, longint got);
      if (want == got) return;
      if (mismatches < 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
      mismatches++;
    endfunction

    // compare a summary beat with the oldest expectation
    function void check_summary(summary_t got);
      summary_t e;
      if (summary_q.size() == 0) begin
        if (mismatches < 10)
          $display("summary beat with nothing expected, total %0d", got.total);
        mismatches++;
        return;
      end
      e = summary_q.pop_front();
      compare("total_length",     longint'(e.total),    longint'(got.total));
      compare("longest_length",   longint'(e.longest),  longint'(got.longest));
      compare("longest_start_x",  longint'(e.long_sx),  longint'(got.long_sx));
      compare("longest_start_y",  longint'(e.long_sy),  longint'(got.long_sy));
      compare("longest_end_x",    longint'(e.long_ex),  longint'(got.long_ex));
      compare("longest_end_y",    longint'(e.long_ey),  longint'(got.long_ey));
      compare("shortest_length",  longint'(e.shortest), longint'(got.shortest));
      compare("shortest_start_x", longint'(e.short_sx), longint'(got.short_sx));
      compare("shortest_start_y", longint'(e.short_sy), longint'(got.short_sy));
      compare("shortest_end_x",   longint'(e.short_ex), longint'(got.short_ex));
      compare("shortest_end_y",   longint'(e.short_ey), longint'(got.short_ey));
      compare("too_few_points",   longint'(e.too_few),  longint'(got.too_few));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  coord_t            in_point_x;
  coord_t            in_point_y;
  logic              in_is_final;
  logic              out_valid;
  logic              out_stall;
  logic [TW-1:0]     out_total_length;
  len_t              out_longest_length;
  coord_t            out_longest_start_x;
  coord_t            out_longest_start_y;
  coord_t            out_longest_end_x;
  coord_t            out_longest_end_y;
  len_t              out_shortest_length;
  coord_t            out_shortest_start_x;
  coord_t            out_shortest_start_y;
  coord_t            out_shortest_end_x;
  coord_t            out_shortest_end_y;
  logic              out_too_few_points;

  route_scoreboard   sb;
  bit                calm;
  bit                hold_req;
  int                cycles = 0;
  int                rand_points;
  coord_t            last_x, last_y;

  polyline_length_min_max_segment #(
    .COORD_WIDTH(CW)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_point_x          (in_point_x),
    .in_point_y          (in_point_y),
    .in_is_final         (in_is_final),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_total_length    (out_total_length),
    .out_longest_length  (out_longest_length),
    .out_longest_start_x (out_longest_start_x),
    .out_longest_start_y (out_longest_start_y),
    .out_longest_end_x   (out_longest_end_x),
    .out_longest_end_y   (out_longest_end_y),
    .out_shortest_length (out_shortest_length),
    .out_shortest_start_x(out_shortest_start_x),
    .out_shortest_start_y(out_shortest_start_y),
    .out_shortest_end_x  (out_shortest_end_x),
    .out_shortest_end_y  (out_shortest_end_y),
    .out_too_few_points  (out_too_few_points)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // offer one point and hold it until the beat is taken
  task automatic drive_point(coord_t x, coord_t y, bit fin);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_point_x  <= x;
    in_point_y  <= y;
    in_is_final <= fin;
    do @(posedge clk); while (in_stall);
    sb.note_point(x, y, fin);
    last_x = x;
    last_y = y;
  endtask

  // one route of random shape and content
  task automatic random_route();
    int     n, sel, mode;
    coord_t x, y;
    sel = $urandom_range(0, 19);
    if (sel == 0)       n = 1;
    else if (sel < 16)  n = $urandom_range(2, 6);
    else if (sel < 19)  n = $urandom_range(7, 15);
    else                n = $urandom_range(16, 40);
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 9);
      case (mode) inside
        [4:6]: begin
          // short hop from the prior point
          x = last_x + coord_t'($urandom_range(0, 511) - 256);
          y = last_y + coord_t'($urandom_range(0, 511) - 256);
        end
        7: begin
          // zero-length segment
          x = last_x;
          y = last_y;
        end
        8: begin
          x = $urandom_range(0, 1) ? coord_t'({1'b1, {(CW-1){1'b0}}})
                                   : coord_t'({1'b0, {(CW-1){1'b1}}});
          y = $urandom_range(0, 1) ? coord_t'({1'b1, {(CW-1){1'b0}}})
                                   : coord_t'({1'b0, {(CW-1){1'b1}}});
        end
        default: begin
          x = coord_t'($urandom());
          y = coord_t'($urandom());
        end
      endcase
      drive_point(x, y, i == n - 1);
    end
    rand_points += n;
  endtask

  // receiver: random stall, one long hold-off on request, checks each beat
  initial begin
    summary_t got;
    int       gap;
    bit       held;
    held      = 1'b0;
    out_stall = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req && !held) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.total    = out_total_length;
      got.longest  = out_longest_length;
      got.long_sx  = out_longest_start_x;
      got.long_sy  = out_longest_start_y;
      got.long_ex  = out_longest_end_x;
      got.long_ey  = out_longest_end_y;
      got.shortest = out_shortest_length;
      got.short_sx = out_shortest_start_x;
      got.short_sy = out_shortest_start_y;
      got.short_ex = out_shortest_end_x;
      got.short_ey = out_shortest_end_y;
      got.too_few  = out_too_few_points;
      sb.check_summary(got);
    end
  end

  // stimulus and end of run
  initial begin
    coord_t lo, hi;
    sb          = new();
    rand_points = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    last_x      = '0;
    last_y      = '0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_point_x  = '0;
    in_point_y  = '0;
    in_is_final = 1'b0;
    lo = coord_t'({1'b1, {(CW-1){1'b0}}});
    hi = coord_t'({1'b0, {(CW-1){1'b1}}});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-point routes
    drive_point('0, '0, 1'b1);
    drive_point(lo, hi, 1'b1);
    // longest possible segment, corner to corner
    drive_point(lo, lo, 1'b0);
    drive_point(hi, hi, 1'b1);
    // full swing on one axis at a time
    drive_point(hi, '0, 1'b0);
    drive_point(lo, '0, 1'b0);
    drive_point(lo, hi, 1'b0);
    drive_point(lo, lo, 1'b1);
    // zero-length segments
    drive_point(16'sd5, 16'sd5, 1'b0);
    drive_point(16'sd5, 16'sd5, 1'b0);
    drive_point(16'sd100, -16'sd100, 1'b1);
    // equal lengths: earliest segment kept for both
    drive_point('0, '0, 1'b0);
    drive_point(16'sd2560, '0, 1'b0);
    drive_point('0, '0, 1'b0);
    drive_point('0, 16'sd2560, 1'b1);
    // later segment of equal length, then a strictly shorter one
    drive_point('0, '0, 1'b0);
    drive_point(16'sd768, 16'sd1024, 1'b0);
    drive_point(16'sd1536, 16'sd2048, 1'b0);
    drive_point(16'sd1537, 16'sd2048, 1'b1);
    // all ones and fractional steps
    drive_point(-16'sd1, -16'sd1, 1'b0);
    drive_point(16'sd1, 16'sd1, 1'b0);
    drive_point(16'sd1, 16'sd2, 1'b1);

    // random routes with idling
    while (rand_points < 700) random_route();
    // random routes back to back
    calm = 1'b1;
    while (rand_points < 1100) random_route();

    // long receiver hold-off while short routes keep coming
    hold_req = 1'b1;
    repeat (40) begin
      drive_point(coord_t'($urandom()), coord_t'($urandom()), 1'b0);
      drive_point(coord_t'($urandom()), coord_t'($urandom()), 1'b1);
    end
    rand_points += 80;

    calm = 1'b0;
    while (rand_points < 1750) random_route();
    in_valid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/plmms_pkg.sv
hdl/plmms_ctrl.sv
hdl/plmms_dp.sv
hdl/polyline_length_min_max_segment.sv
dv/tb_polyline_length_min_max_segment.sv
